// ===== src/tttr_record_decoder_macros.svh =====
// Assertion macros shared by the record decoder RTL.
`ifndef TTTR_RECORD_DECODER_MACROS_SVH
`define TTTR_RECORD_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/trd_pkg.sv =====
// Types and constants shared by the record decoder modules.
package trd_pkg;

    localparam int REC_W       = 32;
    localparam int CHAN_W      = 6;
    localparam int OUT_CHAN_W  = 7;
    localparam int T2_TIME_W   = 25;
    localparam int T3_TIME_W   = 10;
    localparam int DELAY_W     = 15;
    localparam int TIME_W      = 64;
    localparam int OUT_DATA_W  = 88;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CHAN_W-1:0] OFL_CHANNEL = 6'h3F;
    localparam logic [CHAN_W-1:0] MARKER_MAX  = 6'd15;
    localparam logic [CHAN_W-1:0] SYNC_CHANNEL = 6'd0;

    typedef enum logic [1:0] {
        KIND_PHOTON = 2'd0,
        KIND_MARKER = 2'd1,
        KIND_SYNC   = 2'd2
    } t_kind;

    // One classified record as it travels from the front to the back.
    typedef struct packed {
        logic                  ovf;
        logic                  t3;
        t_kind                 kind;
        logic [OUT_CHAN_W-1:0] chan;
        logic [T2_TIME_W-1:0]  tfield;
        logic [DELAY_W-1:0]    dly;
    } t_item;

endpackage

// ===== src/trd_front.sv =====
// Front end: holds the mode register, accepts records and classifies them.
module trd_front
    import trd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [REC_W-1:0] s_axis_tdata,
    input  logic             i_q_full,
    output logic             o_push,
    output t_item            o_item
);

    logic              r_t3_mode;
    logic              special;
    logic [CHAN_W-1:0] ch;
    logic              keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t3_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_t3_mode <= i_cfg_wdata;
        end
    end

    always_comb begin
        special = s_axis_tdata[31];
        ch      = s_axis_tdata[30:25];
        keep    = 1'b0;
        o_item.ovf  = 1'b0;
        o_item.t3   = r_t3_mode;
        o_item.kind = KIND_PHOTON;
        o_item.chan = {1'b0, ch};
        o_item.dly  = '0;
        if (r_t3_mode) begin
            o_item.tfield = {{(T2_TIME_W-T3_TIME_W){1'b0}}, s_axis_tdata[T3_TIME_W-1:0]};
        end else begin
            o_item.tfield = s_axis_tdata[T2_TIME_W-1:0];
        end
        if (special) begin
            if (ch == OFL_CHANNEL) begin
                o_item.ovf = 1'b1;
                keep       = 1'b1;
            end else if (ch >= 6'd1 && ch <= MARKER_MAX) begin
                o_item.kind = KIND_MARKER;
                keep        = 1'b1;
            end else if (ch == SYNC_CHANNEL && !r_t3_mode) begin
                o_item.kind = KIND_SYNC;
                keep        = 1'b1;
            end
        end else begin
            o_item.chan = {1'b0, ch} + 7'd1;
            keep        = 1'b1;
            if (r_t3_mode) begin
                o_item.dly = s_axis_tdata[T3_TIME_W+DELAY_W-1:T3_TIME_W];
            end
        end
    end

    // Ignored special codes are accepted and simply not queued.
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full && keep;

endmodule

// ===== src/trd_queue.sv =====
// Short queue of classified records between the front and the back.
module trd_queue
    import trd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

// ===== src/trd_back.sv =====
// Back end: keeps the overflow offset and forms the corrected output beats.
module trd_back
    import trd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser
);

    logic [TIME_W-1:0]     r_offset;
    logic                  r_valid;
    t_kind                 r_kind;
    logic [OUT_CHAN_W-1:0] r_chan;
    logic [TIME_W-1:0]     r_time;
    logic [DELAY_W-1:0]    r_dly;
    logic [TIME_W-1:0]     ovf_add;
    logic [TIME_W-1:0]     n_offset;
    logic [TIME_W-1:0]     n_time;

    // One overflow record counts wrap periods; the period is a power of two.
    always_comb begin
        if (i_item.t3) begin
            ovf_add = {{(TIME_W-2*T3_TIME_W){1'b0}}, i_item.tfield[T3_TIME_W-1:0],
                       {T3_TIME_W{1'b0}}};
        end else begin
            ovf_add = {{(TIME_W-2*T2_TIME_W){1'b0}}, i_item.tfield, {T2_TIME_W{1'b0}}};
        end
        n_offset = r_offset + ovf_add;
        n_time   = r_offset + {{(TIME_W-T2_TIME_W){1'b0}}, i_item.tfield};
    end

    assign o_pop = !i_empty && (!r_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= !i_item.ovf;
                if (i_item.ovf) begin
                    r_offset <= n_offset;
                end
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_item.ovf) begin
            r_kind <= i_item.kind;
            r_chan <= i_item.chan;
            r_time <= n_time;
            r_dly  <= i_item.dly;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = {2'b00, r_dly, r_time, r_chan};

endmodule

// ===== src/tttr_record_decoder.sv =====
// Path: an accepted record is written into the queue, then popped into the output register.
// Throughput: one record per cycle while the queue is not full; the four-entry queue absorbs output stalls.
// Overflow records take a queue slot but produce no output beat; ignored special codes
// are accepted and dropped at the front. Input stalls only while the queue is full.
// Reset (synchronous, active low) selects T2 mode, zeroes the overflow offset,
// and empties the queue and the output register.
module tttr_record_decoder
    import trd_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,    // t3_mode
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [REC_W-1:0]      s_axis_tdata,   // record
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // channel[6:0], true_time[70:7],
                                                  // delay_time[85:71], zero pad
    output logic [1:0]            m_axis_tuser    // event_kind
);

`include "tttr_record_decoder_macros.svh"

    logic  q_full;
    logic  q_empty;
    logic  push;
    logic  pop;
    t_item push_item;
    t_item pop_item;

    trd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_item        (push_item)
    );

    trd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (pop_item)
    );

    trd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_item        (pop_item),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `TRD_ASSERT_SAME(a_photon_queued, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !s_axis_tdata[31], push, "ordinary photon record was dropped")
    `TRD_ASSERT_SAME(a_no_t3_sync, i_clk, i_rst_n, push && push_item.t3, push_item.kind != KIND_SYNC, "sync event queued in T3 mode")
    `TRD_ASSERT_SAME(a_full_stalls, i_clk, i_rst_n, q_full, !s_axis_tready && !push, "record taken while the queue is full")
    `TRD_ASSERT_NEXT(a_pop_feeds_out, i_clk, i_rst_n, pop && !pop_item.ovf, m_axis_tvalid, "popped event did not reach the output register")

endmodule

// ===== bench/tb_tttr_record_decoder.sv =====
// Self-checking testbench for the T2/T3 time-tagged record decoder.
module tb_tttr_record_decoder;
    import trd_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int LONG_HOLD   = 100;
    localparam int REPORT_MAX  = 10;
    localparam int WRAP_COUNT  = 200;

    // Tracks the overflow offset and the decoded events still owed by the block.
    class tttr_scoreboard;
        typedef struct packed {
            t_kind                 kind;
            logic [OUT_CHAN_W-1:0] chan;
            logic [TIME_W-1:0]     true_time;
            logic [DELAY_W-1:0]    delay_time;
        } t_decoded;

        bit                t3;
        logic [TIME_W-1:0] ovf_offset;
        t_decoded          events_due[$];
        int                errors;

        function new();
            t3         = 1'b0;
            ovf_offset = '0;
            errors     = 0;
        endfunction

        function int pending();
            return events_due.size();
        endfunction

        function void report(string what);
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t: mismatch: %s", $time, what);
        endfunction

        // Decodes one accepted record and queues the event it should produce, if any.
        function void note_record(logic [REC_W-1:0] rec);
            logic                 special;
            logic [CHAN_W-1:0]    chan;
            logic [TIME_W-1:0]    tfield;
            logic [DELAY_W-1:0]   dly;
            t_decoded             ev;
            special = rec[31];
            chan    = rec[30:25];
            if (t3) begin
                tfield = {54'd0, rec[T3_TIME_W-1:0]};
                dly    = rec[24:10];
            end else begin
                tfield = {39'd0, rec[T2_TIME_W-1:0]};
                dly    = '0;
            end
            ev.true_time  = ovf_offset + tfield;
            ev.delay_time = '0;
            if (special) begin
                if (chan == OFL_CHANNEL) begin
                    ovf_offset += t3 ? (tfield << T3_TIME_W) : (tfield << T2_TIME_W);
                    return;
                end
                if (chan >= 6'd1 && chan <= MARKER_MAX) begin
                    ev.kind = KIND_MARKER;
                    ev.chan = {1'b0, chan};
                end else if (chan == SYNC_CHANNEL && !t3) begin
                    ev.kind = KIND_SYNC;
                    ev.chan = '0;
                end else begin
                    return;
                end
            end else begin
                ev.kind       = KIND_PHOTON;
                ev.chan       = {1'b0, chan} + 7'd1;
                ev.delay_time = dly;
            end
            events_due.push_back(ev);
        endfunction

        function void check_event(logic [1:0] kind, logic [OUT_CHAN_W-1:0] chan,
                                  logic [TIME_W-1:0] ttime, logic [DELAY_W-1:0] dly);
            t_decoded exp;
            if (events_due.size() == 0) begin
                report($sformatf("unexpected beat kind=%0d chan=%0d time=%h delay=%h",
                                 kind, chan, ttime, dly));
                return;
            end
            exp = events_due.pop_front();
            if (kind !== exp.kind || chan !== exp.chan || ttime !== exp.true_time ||
                dly !== exp.delay_time)
                report($sformatf({"expected kind=%0d chan=%0d time=%h delay=%h, ",
                                  "got kind=%0d chan=%0d time=%h delay=%h"},
                                 exp.kind, exp.chan, exp.true_time, exp.delay_time,
                                 kind, chan, ttime, dly));
        endfunction

        function void flush();
            while (events_due.size() != 0) begin
                report("event expected but never produced");
                void'(events_due.pop_front());
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_wdata = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [REC_W-1:0]      s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;

    tttr_scoreboard board = new();

    int burst_left = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_cycle = 0;
    int idle_cycles = 0;

    tttr_record_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: cycles through stall patterns, and honors a long hold-off on request.
    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            case ((rx_cycle / 150) % 4)
                0:       m_tready = 1'b1;
                1:       m_tready = ($urandom_range(0, 1) == 1);
                2:       m_tready = ($urandom_range(0, 3) == 0);
                default: m_tready = ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            board.check_event(m_tuser, m_tdata[6:0], m_tdata[70:7], m_tdata[85:71]);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offers one record, with burst gaps, and waits for it to be accepted.
    task automatic send_record(input logic [REC_W-1:0] rec);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = rec;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        board.note_record(rec);
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    // Changes the record format once the block has drained.
    task automatic set_mode(input bit t3);
        while (board.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = t3;
        @(negedge i_clk);
        cfg_we    = 1'b0;
        board.t3  = t3;
    endtask

    function automatic logic [REC_W-1:0] rand_record();
        int unsigned      pick;
        logic [REC_W-1:0] r;
        pick = $urandom_range(0, 99);
        r    = $urandom();
        if (pick < 55) begin
            r[31] = 1'b0;
        end else if (pick < 67) begin
            r[31]    = 1'b1;
            r[30:25] = 6'($urandom_range(1, 15));
        end else if (pick < 75) begin
            r[31]    = 1'b1;
            r[30:25] = SYNC_CHANNEL;
        end else if (pick < 87) begin
            r[31]    = 1'b1;
            r[30:25] = OFL_CHANNEL;
        end else if (pick < 95) begin
            r[31]    = 1'b1;
            r[30:25] = 6'($urandom_range(16, 62));
        end
        return r;
    endfunction

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // T2 corner records.
        set_mode(1'b0);
        send_record({1'b0, 6'd0, 25'd0});
        send_record({1'b0, 6'd63, 25'h1FFFFFF});
        send_record({1'b1, 6'd1, 25'h1234567});
        send_record({1'b1, MARKER_MAX, 25'h1FFFFFF});
        send_record({1'b1, SYNC_CHANNEL, 25'h0ABCDEF});
        send_record({1'b1, OFL_CHANNEL, 25'd1});
        send_record({1'b0, 6'd5, 25'd100});
        send_record({1'b1, OFL_CHANNEL, 25'd0});
        send_record({1'b1, OFL_CHANNEL, 25'h1FFFFFF});
        send_record({1'b1, 6'd16, 25'h155AAAA});
        send_record({1'b1, 6'd62, 25'h0AA5555});
        send_record({1'b0, 6'd31, 25'h0000001});

        // T3 corner records; markers must drop the delay bits.
        set_mode(1'b1);
        send_record({1'b0, 6'd0, 15'h7FFF, 10'h3FF});
        send_record({1'b0, 6'd63, 15'h0000, 10'h000});
        send_record({1'b1, 6'd1, 15'h7FFF, 10'h155});
        send_record({1'b1, MARKER_MAX, 15'h2AAA, 10'h3FF});
        send_record({1'b1, SYNC_CHANNEL, 15'h1234, 10'h2AA});
        send_record({1'b1, OFL_CHANNEL, 15'h7FFF, 10'd1});
        send_record({1'b0, 6'd7, 15'h4321, 10'd9});
        send_record({1'b1, OFL_CHANNEL, 15'h0000, 10'h3FF});
        send_record({1'b1, 6'd40, 15'h7FFF, 10'h3FF});
        send_record({1'b0, 6'd33, 15'h0001, 10'h200});

        for (int phase = 0; phase < 4; phase++) begin
            set_mode(phase % 2 == 0);
            // The long hold-off starts while the sender keeps offering records.
            if (phase == 2)
                hold_req++;
            for (int n = 0; n < 200; n++)
                send_record(rand_record());
        end

        // Grow the offset with full-scale T2 overflows between photons.
        set_mode(1'b0);
        for (int n = 0; n < WRAP_COUNT; n++) begin
            if (n % 50 == 0)
                send_record({1'b0, 6'd10, 25'h1FFFFFF});
            send_record({1'b1, OFL_CHANNEL, 25'h1FFFFFF});
        end
        send_record({1'b0, 6'd10, 25'h1FFFFFF});
        send_record({1'b1, 6'd3, 25'h1FFFFFF});
        send_record({1'b1, SYNC_CHANNEL, 25'h0000000});
        set_mode(1'b1);
        for (int n = 0; n < 20; n++)
            send_record(rand_record());

        while (board.pending() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        board.flush();
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== tttr_record_decoder.f =====
+incdir+src
src/trd_pkg.sv
src/trd_front.sv
src/trd_queue.sv
src/trd_back.sv
src/tttr_record_decoder.sv
bench/tb_tttr_record_decoder.sv
